// ===== hdl/ibs_pkg.sv =====
// ----------------------------------------------------------------------------
// ibs_pkg
// Shared widths and divider handshake types for the integer bucket sort unit.
// ----------------------------------------------------------------------------
package ibs_pkg;

	localparam int DATA_W = 32;
	localparam int CFG_W  = 5;
	// wide enough for max - min + 1 without overflow
	localparam int DIV_W  = 34;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hdl/ibs_div.sv =====
// ----------------------------------------------------------------------------
// ibs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ibs_div (
	input  logic             clk,
	input  logic             arst_n,
	input  ibs_pkg::div_req_t req,
	output ibs_pkg::div_rsp_t rsp
);
	import ibs_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DIV_W:0]   rem_sh;
	logic             ge;
	logic [DIV_W:0]   rem_sub;

	// shift in the next dividend bit and try the subtract
	always_comb begin
		rem_sh  = {rem_q, quo_q[DIV_W-1]};
		ge      = rem_sh >= {1'b0, dsr_q};
		rem_sub = rem_sh - {1'b0, dsr_q};
	end

	// hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// advance remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without busy");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q != CNT_W'(1) |=> !done_q) else $error("early done");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("done while busy");

endmodule

// ===== hdl/integer_bucket_sort_unit.sv =====
// ----------------------------------------------------------------------------
// integer_bucket_sort_unit
// Bucket sort of a set of signed 32-bit values with insertion-sorted buckets.
// ----------------------------------------------------------------------------
// Usage:
//   Load values on the input channel (value, last_in), one beat per cycle,
//   while in_ready is high. The beat with last_in set closes the set; values
//   beyond MAX_ITEMS are dropped. The unit then computes the bucket width on
//   the serial divider, reads each stored value, divides again for its
//   bucket and inserts it into that bucket's region of the bucket memory,
//   shifting larger entries up one by one. Results leave on the output
//   channel in ascending order, last_out set on the final one; in_ready is
//   low from the closing beat until then. Values are sorted one at a time
//   through the shared divider and the bucket memory.
//   A stalled receiver holds the output beat and the sort simply waits.
//   num_buckets is written on its own channel, which is always ready.
//   Reset empties the set, clears all bucket fills and sets num_buckets to 4.
// ----------------------------------------------------------------------------
module integer_bucket_sort_unit #(
	parameter int MAX_ITEMS   = 64,
	parameter int MAX_BUCKETS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ibs_pkg::CFG_W-1:0]    num_buckets,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [ibs_pkg::DATA_W-1:0] value,
	input  logic                         last_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [ibs_pkg::DATA_W-1:0] sorted_value,
	output logic                         last_out
);
	import ibs_pkg::*;

	localparam int IW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW  = $clog2(MAX_ITEMS + 1);
	localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int BCW = $clog2(MAX_BUCKETS + 1);
	localparam int AW  = $clog2(MAX_BUCKETS * MAX_ITEMS);
	localparam int BK_DEPTH = MAX_BUCKETS * MAX_ITEMS;

	localparam logic [3:0] S_LOAD    = 4'd0;
	localparam logic [3:0] S_WST     = 4'd1;
	localparam logic [3:0] S_WDIV    = 4'd2;
	localparam logic [3:0] S_IRD     = 4'd3;
	localparam logic [3:0] S_IDIV    = 4'd4;
	localparam logic [3:0] S_IWAIT   = 4'd5;
	localparam logic [3:0] S_INS_RD  = 4'd6;
	localparam logic [3:0] S_INS_CMP = 4'd7;
	localparam logic [3:0] S_ERD     = 4'd8;
	localparam logic [3:0] S_EOUT    = 4'd9;

	logic [3:0]              state_q;
	logic [CFG_W-1:0]        bcount_q;
	logic [CW-1:0]           cnt_q;
	logic signed [DATA_W-1:0] min_q;
	logic signed [DATA_W-1:0] max_q;
	logic [DIV_W-1:0]        width_q;
	logic [CW-1:0]           i_q;
	logic [CW-1:0]           j_q;
	logic [BW-1:0]           b_q;
	logic signed [DATA_W-1:0] v_q;
	logic [BW-1:0]           eb_q;
	logic [CW-1:0]           ei_q;
	logic [CW-1:0]           ecnt_q;
	logic [CW-1:0]           fill_q [MAX_BUCKETS];

	logic signed [DATA_W-1:0] item_mem [MAX_ITEMS];
	logic signed [DATA_W-1:0] item_rd_q;
	logic signed [DATA_W-1:0] bk_mem [BK_DEPTH];
	logic signed [DATA_W-1:0] bk_rd_q;

	logic             in_fire;
	logic             out_fire;
	logic             cfg_fire;
	logic [BCW-1:0]   bc_eff;
	logic [BW-1:0]    bsel;
	logic             shift_up;
	logic             ins_done;
	logic             bk_we;
	logic [AW-1:0]    bk_waddr;
	logic signed [DATA_W-1:0] bk_wdata;
	logic             bk_re;
	logic [AW-1:0]    bk_raddr;
	div_req_t         dreq;
	div_rsp_t         drsp;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;
	assign in_ready  = (state_q == S_LOAD);
	assign in_fire   = in_valid & in_ready;
	assign out_valid = (state_q == S_EOUT);
	assign out_fire  = out_valid & out_ready;
	assign sorted_value = bk_rd_q;
	assign last_out  = (ecnt_q == cnt_q - 1'b1);

	// clamp the bucket count into 1..MAX_BUCKETS
	always_comb begin
		if (bcount_q == '0)
			bc_eff = BCW'(1);
		else if (int'(bcount_q) > MAX_BUCKETS)
			bc_eff = BCW'(MAX_BUCKETS);
		else
			bc_eff = BCW'(bcount_q);
	end

	// clamp the quotient to the top bucket
	always_comb begin
		if (drsp.quotient > DIV_W'(bc_eff - 1'b1))
			bsel = BW'(bc_eff - 1'b1);
		else
			bsel = BW'(drsp.quotient);
	end

	// route divider requests: width first, then one per stored value
	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = '0;
		dreq.divisor  = width_q;
		case (state_q)
			S_WST: begin
				dreq.start    = 1'b1;
				dreq.dividend = DIV_W'(signed'(max_q)) - DIV_W'(signed'(min_q))
					+ DIV_W'(1);
				dreq.divisor  = DIV_W'(bc_eff);
			end
			S_IDIV: begin
				dreq.start    = 1'b1;
				dreq.dividend = DIV_W'(signed'(item_rd_q)) - DIV_W'(signed'(min_q));
			end
			default: ;
		endcase
	end

	ibs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// insertion step: move the neighbor up or drop the key in place
	always_comb begin
		shift_up = (state_q == S_INS_CMP) && (bk_rd_q > v_q);
		ins_done = ((state_q == S_INS_RD) && (j_q == '0))
			|| ((state_q == S_INS_CMP) && !(bk_rd_q > v_q));
		bk_we    = shift_up || ins_done;
		bk_waddr = AW'(b_q) * AW'(MAX_ITEMS) + AW'(j_q[IW-1:0]);
		bk_wdata = shift_up ? bk_rd_q : v_q;
		bk_re    = 1'b0;
		bk_raddr = AW'(eb_q) * AW'(MAX_ITEMS) + AW'(ei_q[IW-1:0]);
		if (state_q == S_INS_RD && j_q != '0) begin
			bk_re    = 1'b1;
			bk_raddr = AW'(b_q) * AW'(MAX_ITEMS) + AW'(j_q[IW-1:0] - 1'b1);
		end else if (state_q == S_ERD && ei_q != fill_q[eb_q]) begin
			bk_re = 1'b1;
		end
	end

	// item store
	always_ff @(posedge clk) begin
		if (in_fire && cnt_q < CW'(MAX_ITEMS))
			item_mem[cnt_q[IW-1:0]] <= value;
		if (state_q == S_IRD)
			item_rd_q <= item_mem[i_q[IW-1:0]];
	end

	// bucket store
	always_ff @(posedge clk) begin
		if (bk_we)
			bk_mem[bk_waddr] <= bk_wdata;
		if (bk_re)
			bk_rd_q <= bk_mem[bk_raddr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire && cnt_q < CW'(MAX_ITEMS)) begin
			if (cnt_q == '0 || value < min_q)
				min_q <= value;
			if (cnt_q == '0 || value > max_q)
				max_q <= value;
		end
		if (state_q == S_WDIV && drsp.done)
			width_q <= drsp.quotient + DIV_W'(1);
		if (state_q == S_IDIV)
			v_q <= item_rd_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			bcount_q <= CFG_W'(4);
			cnt_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			b_q      <= '0;
			eb_q     <= '0;
			ei_q     <= '0;
			ecnt_q   <= '0;
			for (int k = 0; k < MAX_BUCKETS; k++)
				fill_q[k] <= '0;
		end else begin
			if (cfg_fire)
				bcount_q <= num_buckets;
			case (state_q)
				S_LOAD: begin
					if (in_fire) begin
						if (cnt_q < CW'(MAX_ITEMS))
							cnt_q <= cnt_q + 1'b1;
						if (last_in)
							state_q <= S_WST;
					end
				end
				S_WST: state_q <= S_WDIV;
				S_WDIV: begin
					if (drsp.done) begin
						i_q     <= '0;
						state_q <= S_IRD;
					end
				end
				S_IRD:  state_q <= S_IDIV;
				S_IDIV: state_q <= S_IWAIT;
				S_IWAIT: begin
					if (drsp.done) begin
						b_q     <= bsel;
						j_q     <= fill_q[bsel];
						state_q <= S_INS_RD;
					end
				end
				S_INS_RD: begin
					if (j_q != '0)
						state_q <= S_INS_CMP;
				end
				S_INS_CMP: begin
					if (shift_up) begin
						j_q     <= j_q - 1'b1;
						state_q <= S_INS_RD;
					end
				end
				S_ERD: begin
					if (ei_q == fill_q[eb_q]) begin
						eb_q <= eb_q + 1'b1;
						ei_q <= '0;
					end else begin
						state_q <= S_EOUT;
					end
				end
				S_EOUT: begin
					if (out_fire) begin
						ei_q   <= ei_q + 1'b1;
						ecnt_q <= ecnt_q + 1'b1;
						if (last_out) begin
							cnt_q   <= '0;
							state_q <= S_LOAD;
							for (int k = 0; k < MAX_BUCKETS; k++)
								fill_q[k] <= '0;
						end else begin
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
			// close out one insertion
			if (ins_done) begin
				fill_q[b_q] <= fill_q[b_q] + 1'b1;
				i_q         <= i_q + 1'b1;
				if (i_q + 1'b1 == cnt_q) begin
					eb_q    <= '0;
					ei_q    <= '0;
					ecnt_q  <= '0;
					state_q <= S_ERD;
				end else begin
					state_q <= S_IRD;
				end
			end
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("load and emit overlap");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ITEMS)) else $error("item count overflow");
	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && last_out |=> in_ready && cnt_q == '0)
		else $error("set not closed after last beat");
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != '0) else $error("emit with empty set");

endmodule
